/* hw/rtl/bgc_pkg.sv */
// shared types and constants for the button gesture classifier
package bgc_pkg;

    localparam int unsigned NOW_W      = 32;
    localparam int unsigned RECOVERY_W = 16;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [RECOVERY_W-1:0] RECOVERY_RESET = 16'd250;
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = 4'd15;

    typedef enum logic [2:0] {
        CMD_NOTHING = 3'd0,
        CMD_HOLD    = 3'd1,
        CMD_RELEASE = 3'd2,
        CMD_CLICK   = 3'd3,
        CMD_DOUBLE  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic             read_req;
        logic [NOW_W-1:0] now_ms;
        logic             pin_level;
    } poll_t;

    typedef struct packed {
        cmd_t taken;
        cmd_t command;
    } result_t;

endpackage

/* hw/rtl/button_gesture_classifier_core.sv */
// top level of the button gesture classifier
// Classifies polls of an active-low push button into hold, release, click and
// double click commands. Each input item is one poll (pin level, millisecond
// timestamp, read request) and yields exactly one result item carrying the
// command registered by that poll and the command handed to the reader. An
// item is registered on entry, classified against the gesture state by short
// logic and lands in the output register: one item is taken per cycle while
// the output does not stall, and m_tvalid rises once the item has gone from the
// input register into the output register. The state update loop holds the
// elapsed-time subtract, the 16x4 recovery threshold multiply and the compares,
// all feeding the gesture state register. The input register keeps accepting
// while a result waits, stalling only when both registers are full. The user
// must write recovery_ms (cfg_we/cfg_wdata, reset 250) only when idle, unchecked.
module button_gesture_classifier_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic [bgc_pkg::RECOVERY_W-1:0] cfg_wdata,   // recovery_ms
    // poll items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bgc_pkg::IN_DATA_W-1:0]  s_tdata,     // pin_level, now_ms[31:0], read_req
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bgc_pkg::OUT_DATA_W-1:0] m_tdata      // command[2:0], taken[2:0]
);
    import bgc_pkg::*;

    logic    item_valid;
    poll_t   item;
    logic    up_ready;
    logic    fire;
    result_t result;

    // an item moves through classification when the output slot is free
    assign fire = item_valid && up_ready;

    bgc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .down_ready (up_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    // gesture state lives here and updates once per item
    bgc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    bgc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .result   (result),
        .up_ready (up_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hw/rtl/bgc_in_stage.sv */
// input register stage for poll items
module bgc_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bgc_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          down_ready,
    output logic                          item_valid,
    output bgc_pkg::poll_t                item
);
    import bgc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    poll_t item_reg;

    assign s_tready   = !valid_reg || down_ready;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.pin_level <= s_tdata[0];
            item_reg.now_ms    <= s_tdata[NOW_W:1];
            item_reg.read_req  <= s_tdata[NOW_W+1];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hw/rtl/bgc_classify.sv */
// gesture state and per-poll classification logic
module bgc_classify (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bgc_pkg::RECOVERY_W-1:0] cfg_wdata,
    input  logic                           fire,
    input  bgc_pkg::poll_t                 item,
    output bgc_pkg::result_t               result
);
    import bgc_pkg::*;

    localparam int unsigned THRESH_W = RECOVERY_W + COUNT_W;

    logic [RECOVERY_W-1:0] recovery_reg;
    logic                  was_pressed_reg, was_pressed_next;
    logic [NOW_W-1:0]      press_time_reg, press_time_next;
    logic [COUNT_W-1:0]    click_count_reg, click_count_next;
    cmd_t                  cur_cmd_reg, cur_cmd_next;
    logic                  consumed_reg, consumed_next;

    logic                  pressed;
    logic [NOW_W-1:0]      elapsed;
    logic [THRESH_W-1:0]   thresh;
    logic                  idle;
    logic                  early;
    logic [COUNT_W-1:0]    count_step;
    cmd_t                  taken;

    assign pressed = !item.pin_level;
    assign elapsed = item.now_ms - press_time_reg;
    assign thresh  = {{COUNT_W{1'b0}}, recovery_reg} * {{RECOVERY_W{1'b0}}, click_count_reg};
    assign idle    = !pressed && (elapsed > {{(NOW_W-THRESH_W){1'b0}}, thresh});

    always_comb begin
        click_count_next = click_count_reg;
        cur_cmd_next     = CMD_NOTHING;
        consumed_next    = consumed_reg;
        was_pressed_next = was_pressed_reg;
        press_time_next  = press_time_reg;
        early            = 1'b0;
        count_step       = click_count_reg;
        taken            = CMD_NOTHING;

        // idle long enough: forget clicks, close out a hold
        if (idle) begin
            click_count_next = '0;
            count_step       = '0;
            if (cur_cmd_reg == CMD_HOLD) begin
                cur_cmd_next  = CMD_RELEASE;
                consumed_next = 1'b0;
                early         = 1'b1;
            end
        end

        if (!early) begin
            if (pressed && !was_pressed_reg) begin
                press_time_next = item.now_ms;
                cur_cmd_next    = CMD_HOLD;
                consumed_next   = 1'b0;
            end

            if (!pressed && was_pressed_reg) begin
                if (elapsed < {{(NOW_W-RECOVERY_W){1'b0}}, recovery_reg}) begin
                    consumed_next = 1'b0;
                    if (count_step < COUNT_MAX) begin
                        count_step = count_step + 4'd1;
                    end
                    click_count_next = count_step;
                    if (count_step == 4'd1) begin
                        cur_cmd_next = CMD_CLICK;
                    end else if (count_step == 4'd2) begin
                        cur_cmd_next = CMD_DOUBLE;
                    end
                end
            end else if (pressed && was_pressed_reg) begin
                cur_cmd_next  = CMD_HOLD;
                consumed_next = 1'b0;
            end

            was_pressed_next = pressed;
        end

        // reader takes the command once
        if (item.read_req && !consumed_next) begin
            taken = cur_cmd_next;
        end
        if (item.read_req) begin
            consumed_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recovery_reg    <= RECOVERY_RESET;
            was_pressed_reg <= 1'b0;
            press_time_reg  <= '0;
            click_count_reg <= '0;
            cur_cmd_reg     <= CMD_NOTHING;
            consumed_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                recovery_reg <= cfg_wdata;
            end
            if (fire) begin
                was_pressed_reg <= was_pressed_next;
                press_time_reg  <= press_time_next;
                click_count_reg <= click_count_next;
                cur_cmd_reg     <= cur_cmd_next;
                consumed_reg    <= consumed_next;
            end
        end
    end

    assign result.command = cur_cmd_next;
    assign result.taken   = taken;

    a_taken_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && taken != CMD_NOTHING) |-> (taken == cur_cmd_next))
        else $error("taken command differs from registered command");

    a_read_consumes: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.read_req) |=> consumed_reg)
        else $error("read did not set consumed");

    a_release_after_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && cur_cmd_next == CMD_RELEASE) |-> (cur_cmd_reg == CMD_HOLD))
        else $error("release without a preceding hold");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(click_count_reg) && $stable(cur_cmd_reg)))
        else $error("gesture state changed without an item");

endmodule

/* hw/rtl/bgc_out_stage.sv */
// output register stage for result items
module bgc_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fire,
    input  bgc_pkg::result_t               result,
    output logic                           up_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bgc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import bgc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign up_ready   = !valid_reg || m_tready;
    assign valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-6){1'b0}}, data_reg.taken, data_reg.command};

endmodule

/* bench/button_gesture_classifier_core_tb.sv */
// self-checking testbench for the button gesture classifier core
module button_gesture_classifier_core_tb;
    import bgc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_POLLS   = 235;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned HOLD_OFF_LEN  = 400;

    // predicts every result of the block and checks the results as they come out
    class gesture_scoreboard;
        logic [RECOVERY_W-1:0] recovery;
        logic                  was_pressed;
        logic [NOW_W-1:0]      press_time;
        logic [COUNT_W-1:0]    click_count;
        cmd_t                  current_cmd;
        logic                  consumed;
        result_t               pending_results[$];
        int unsigned           errors;
        int unsigned           polls_noted;
        int unsigned           results_checked;
        int unsigned           cmd_tally[5];

        function new();
            recovery     = RECOVERY_RESET;
            was_pressed  = 1'b0;
            press_time   = '0;
            click_count  = '0;
            current_cmd  = CMD_NOTHING;
            consumed     = 1'b0;
            errors       = 0;
            polls_noted  = 0;
            results_checked = 0;
            foreach (cmd_tally[i]) cmd_tally[i] = 0;
        endfunction

        function void set_recovery(logic [RECOVERY_W-1:0] value);
            recovery = value;
        endfunction

        // gesture state update for one poll, returns the expected result
        function result_t classify_poll(logic pin_level, logic [NOW_W-1:0] now_ms,
                                        logic read_req);
            logic             pressed;
            cmd_t             last_cmd;
            logic [NOW_W-1:0] elapsed;
            logic [NOW_W-1:0] idle_limit;
            logic             release_poll;
            result_t          res;
            pressed      = ~pin_level;
            last_cmd     = current_cmd;
            elapsed      = now_ms - press_time;
            idle_limit   = NOW_W'(recovery) * NOW_W'(click_count);
            release_poll = 1'b0;
            current_cmd  = CMD_NOTHING;
            if (!pressed && elapsed > idle_limit) begin
                click_count = '0;
                if (last_cmd == CMD_HOLD) begin
                    current_cmd  = CMD_RELEASE;
                    consumed     = 1'b0;
                    release_poll = 1'b1;
                end
            end
            if (!release_poll) begin
                if (pressed && !was_pressed) begin
                    press_time  = now_ms;
                    current_cmd = CMD_HOLD;
                    consumed    = 1'b0;
                end
                if (!pressed && was_pressed) begin
                    if (elapsed < NOW_W'(recovery)) begin
                        consumed = 1'b0;
                        if (click_count < COUNT_MAX)
                            click_count = click_count + 4'd1;
                        if (click_count == 4'd1)
                            current_cmd = CMD_CLICK;
                        else if (click_count == 4'd2)
                            current_cmd = CMD_DOUBLE;
                    end
                end else if (pressed && was_pressed) begin
                    current_cmd = CMD_HOLD;
                    consumed    = 1'b0;
                end
                was_pressed = pressed;
            end
            res.command = current_cmd;
            res.taken   = CMD_NOTHING;
            if (read_req && !consumed) begin
                consumed  = 1'b1;
                res.taken = current_cmd;
            end
            return res;
        endfunction

        function void note_poll(logic pin_level, logic [NOW_W-1:0] now_ms, logic read_req);
            result_t res;
            res = classify_poll(pin_level, now_ms, read_req);
            pending_results.push_back(res);
            cmd_tally[res.command] = cmd_tally[res.command] + 1;
            polls_noted = polls_noted + 1;
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[5:0]);
            results_checked = results_checked + 1;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no poll waiting: command %0d taken %0d",
                         $time, got.command, got.taken);
                errors = errors + 1;
                return;
            end
            want = pending_results.pop_front();
            if (got.command !== want.command) begin
                $display("%0t: command mismatch: expected %0d actual %0d",
                         $time, want.command, got.command);
                errors = errors + 1;
            end
            if (got.taken !== want.taken) begin
                $display("%0t: taken mismatch: expected %0d actual %0d",
                         $time, want.taken, got.taken);
                errors = errors + 1;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [RECOVERY_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    gesture_scoreboard sb = new();

    int unsigned      src_idle_pct   = 0;
    int unsigned      sink_stall_pct = 0;
    bit               hold_off_req   = 1'b0;
    int unsigned      cycle_count    = 0;
    int unsigned      polls_sent     = 0;
    int unsigned      settings_used  = 1;
    logic [NOW_W-1:0] clock_ms       = '0;

    button_gesture_classifier_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog on the whole run
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk) cycle_count++;
        $display("button_gesture_classifier_core regression: fail");
        $finish;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // offers one poll item, returns at the falling edge after it was accepted
    task automatic send_poll(logic pin_level, logic [NOW_W-1:0] now_ms, logic read_req);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, read_req, now_ms, pin_level};
        do @(posedge aclk); while (!s_tready);
        sb.note_poll(pin_level, now_ms, read_req);
        polls_sent++;
        @(negedge aclk);
    endtask

    // advances the millisecond clock and polls with a random read request
    task automatic poll_step(logic pin_level, int unsigned delta_ms);
        clock_ms = clock_ms + delta_ms;
        send_poll(pin_level, clock_ms, 1'($urandom_range(0, 1)));
    endtask

    // writes recovery_ms once every result is out and the pipeline is empty
    task automatic write_recovery(logic [RECOVERY_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.set_recovery(value);
        settings_used++;
    endtask

    // random gestures scaled to the current recovery window
    task automatic run_gestures(int unsigned rec, int unsigned count);
        int unsigned kind;
        int unsigned reps;
        int unsigned first;
        first = polls_sent;
        while (polls_sent - first < count) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    // click bursts, a long one can run the count into saturation
                    reps = (kind == 3) ? $urandom_range(4, 20) : $urandom_range(1, 3);
                    repeat (reps) begin
                        poll_step(1'b0, $urandom_range(0, rec / 4));
                        repeat ($urandom_range(0, 2)) poll_step(1'b0, $urandom_range(0, rec / 8));
                        poll_step(1'b1, $urandom_range(0, rec / 4));
                        repeat ($urandom_range(0, 2)) poll_step(1'b1, $urandom_range(0, rec / 4));
                    end
                end
                4, 5: begin
                    // long press, released around or after the window
                    poll_step(1'b0, $urandom_range(0, rec));
                    repeat ($urandom_range(1, 4)) poll_step(1'b0, $urandom_range(rec / 2, 2 * rec));
                    repeat ($urandom_range(1, 3)) poll_step(1'b1, $urandom_range(0, rec));
                end
                6, 7: begin
                    // button up for a while, idle clear may or may not hit
                    repeat ($urandom_range(1, 4)) poll_step(1'b1, $urandom_range(0, 32 * rec));
                end
                8: begin
                    // noise: arbitrary timestamps and levels
                    repeat ($urandom_range(1, 3)) begin
                        clock_ms = $urandom;
                        send_poll(1'($urandom_range(0, 1)), clock_ms, 1'($urandom_range(0, 1)));
                    end
                end
                default: begin
                    // release right around the recovery boundary
                    poll_step(1'b1, $urandom_range(0, 32 * rec));
                    poll_step(1'b0, $urandom_range(1, rec));
                    poll_step(1'b1, rec - 1 + $urandom_range(0, 2));
                end
            endcase
        end
    endtask

    initial begin
        int unsigned           p;
        logic [RECOVERY_W-1:0] rec;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed polls at the reset window of 250 ms
        send_poll(1'b1, 32'd0, 1'b1);             // up at reset, read gives nothing
        send_poll(1'b0, 32'd100, 1'b0);           // press edge
        send_poll(1'b0, 32'd150, 1'b1);           // hold repeats, read it
        send_poll(1'b0, 32'd160, 1'b1);           // hold again clears consumed
        send_poll(1'b1, 32'd200, 1'b0);           // idle with zero clicks gives release
        send_poll(1'b1, 32'd210, 1'b1);           // click counted on the poll after release
        send_poll(1'b1, 32'd220, 1'b1);           // already consumed
        send_poll(1'b0, 32'd230, 1'b0);
        send_poll(1'b1, 32'd240, 1'b1);           // double click
        send_poll(1'b0, 32'd250, 1'b0);
        send_poll(1'b1, 32'd260, 1'b1);           // third click registers nothing
        send_poll(1'b1, 32'd2000, 1'b1);          // idle clears the count
        send_poll(1'b0, 32'hFFFF_FFF0, 1'b0);     // press just before wrap
        send_poll(1'b1, 32'h0000_0010, 1'b1);     // elapsed across the wrap
        send_poll(1'b1, 32'h0000_0020, 1'b1);
        send_poll(1'b0, 32'h0000_1000, 1'b0);
        send_poll(1'b0, 32'h0000_8000, 1'b1);
        send_poll(1'b1, 32'h0000_8001, 1'b0);     // release after a long hold
        send_poll(1'b1, 32'h0000_8002, 1'b1);     // too late for a click
        send_poll(1'b1, 32'hFFFF_FFFF, 1'b1);
        send_poll(1'b0, 32'h0000_0000, 1'b0);
        send_poll(1'b0, 32'hFFFF_FFFF, 1'b1);
        send_poll(1'b1, 32'h0000_0000, 1'b1);

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0, 7:    rec = RECOVERY_RESET;
                1, 5:    rec = 16'd1;
                2, 4:    rec = 16'hFFFF;
                default: rec = 16'($urandom_range(2, 65534));
            endcase
            write_recovery(rec);
            case (p % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 48; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 48; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            // long receiver hold-off while polls keep coming, fills the block
            if (p == 0)
                hold_off_req = 1'b1;
            run_gestures(32'(rec), PHASE_POLLS);
        end

        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.pending_results.size() != 0) begin
            $display("%0t: %0d expected results never came out",
                     $time, sb.pending_results.size());
            sb.errors = sb.errors + 1;
        end

        $display("covered %0d polls and %0d results over %0d recovery settings",
                 polls_sent, sb.results_checked, settings_used);
        $display("commands: hold %0d release %0d click %0d double %0d nothing %0d",
                 sb.cmd_tally[CMD_HOLD], sb.cmd_tally[CMD_RELEASE],
                 sb.cmd_tally[CMD_CLICK], sb.cmd_tally[CMD_DOUBLE],
                 sb.cmd_tally[CMD_NOTHING]);
        if (sb.errors == 0) begin
            $display("button_gesture_classifier_core regression: pass");
        end else begin
            $display("button_gesture_classifier_core regression: fail");
        end
        $finish;
    end

endmodule
